### src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared constants for the pitot frame airspeed block
// Field widths, fixed-point scale factors and step counts of the serial units.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PRESS_W  = 14;
    localparam int TEMP_W   = 11;
    localparam int TDEG_W   = 12;
    localparam int SPEED_W  = 16;

    localparam int AVG_WEIGHT_DEF = 6;

    localparam logic [STATUS_W-1:0] STATUS_READY = 2'd0;

    // airspeed: |137411*P - 1125670000| * 65536 / 100000, then floor sqrt
    localparam logic [17:0] SPEED_GAIN   = 18'd137411;
    localparam logic [31:0] SPEED_OFFSET = 32'd1125670000;
    localparam logic [16:0] SPEED_DIV    = 17'd100000;
    localparam int          SPD_STEPS    = 31;

    // temperature: (1000*T - 511750) / 10235, truncated toward zero
    localparam logic [9:0]  TEMP_GAIN   = 10'd1000;
    localparam logic [20:0] TEMP_OFFSET = 21'd511750;
    localparam logic [13:0] TEMP_DIV    = 14'd10235;
    localparam int          TMP_STEPS   = 8;

    localparam int ROOT_STEPS = 16;
    localparam int CNT_W      = 5;

    // pressure count at zero differential pressure
    localparam logic [PRESS_W-1:0] PRESS_ZERO = 14'd8192;

endpackage

### src/pitot_frame_airspeed.sv
// ----------------------------------------------------------------------------
// pitot_frame_airspeed: pitot sensor frame decoder and airspeed readout
// Decodes a four-byte frame, folds ready samples into running averages and
// reports status, averages, temperature and signed Q8.8 airspeed.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one four-byte frame per beat.
// Output channel (out_valid/out_ready) carries one result beat per frame.
// A frame with status ready first runs a bit-serial divide by AVG_WEIGHT on
// both averages; every frame then takes a step of constant multiplies, a
// bit-serial divide for the airspeed radicand (the temperature divide runs
// alongside it at the start), a bit-serial square root and a final step to
// load the output register.
// One frame is worked on at a time; the next frame can be accepted in the
// cycle after the result is loaded. The serial divide and square-root chain
// sets how long a frame takes.
// The result sits in an output register, so a new frame is accepted and
// processed while the previous result waits; the block holds in its final
// step only if a second result is ready before the first is taken.
// Reset clears both running averages to zero and empties the output register.
// ----------------------------------------------------------------------------
module pitot_frame_airspeed
    import pfa_pkg::*;
#(
    parameter int AVG_WEIGHT = AVG_WEIGHT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BYTE_W-1:0]          frame_byte0,
    input  logic [BYTE_W-1:0]          frame_byte1,
    input  logic [BYTE_W-1:0]          frame_byte2,
    input  logic [BYTE_W-1:0]          frame_byte3,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        sensor_status,
    output logic [PRESS_W-1:0]         pressure_average,
    output logic [TEMP_W-1:0]          temp_average,
    output logic signed [TDEG_W-1:0]   temperature_decidegrees,
    output logic signed [SPEED_W-1:0]  airspeed_q8
);

    localparam int WB    = $clog2(AVG_WEIGHT);
    localparam int SUM_W = PRESS_W + WB;
    localparam logic [SUM_W-1:0] WGT_M1 = SUM_W'(AVG_WEIGHT - 1);
    localparam logic [WB:0]      WGT    = (WB + 1)'(AVG_WEIGHT);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FOLD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // control and architectural state
    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [PRESS_W-1:0]  pavg_reg, pavg_next;
    logic [TEMP_W-1:0]   tavg_reg, tavg_next;

    // datapath
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WB-1:0]       pf_rem_reg, pf_rem_next;
    logic [PRESS_W-1:0]  pf_sh_reg, pf_sh_next;
    logic [WB-1:0]       tf_rem_reg, tf_rem_next;
    logic [PRESS_W-1:0]  tf_sh_reg, tf_sh_next;
    logic [16:0]         sd_rem_reg, sd_rem_next;
    logic [30:0]         sd_sh_reg, sd_sh_next;
    logic [13:0]         td_rem_reg, td_rem_next;
    logic [7:0]          td_sh_reg, td_sh_next;
    logic                td_neg_reg, td_neg_next;
    logic [16:0]         rt_rem_reg, rt_rem_next;
    logic [15:0]         rt_root_reg, rt_root_next;
    logic [31:0]         rt_rad_reg, rt_rad_next;

    // output register
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [PRESS_W-1:0]  o_pavg_reg, o_pavg_next;
    logic [TEMP_W-1:0]   o_tavg_reg, o_tavg_next;
    logic [TDEG_W-1:0]   o_tdeg_reg, o_tdeg_next;
    logic [SPEED_W-1:0]  o_speed_reg, o_speed_next;

    // combinational helpers
    logic [PRESS_W-1:0]  praw;
    logic [TEMP_W-1:0]   traw;
    logic [SUM_W-1:0]    psum, tsum;
    logic [WB:0]         pf_trial, tf_trial;
    logic                pf_ge, tf_ge;
    logic [WB:0]         pf_diff, tf_diff;
    logic [31:0]         sp_prod;
    logic [32:0]         sp_d, sp_abs;
    logic [20:0]         tp_num, tp_mag;
    logic                tp_neg;
    logic [17:0]         sd_trial, sd_diff;
    logic                sd_ge;
    logic [14:0]         td_trial, td_diff;
    logic                td_ge;
    logic [18:0]         rt_cur, rt_trial, rt_diff;
    logic                rt_ge;
    logic [TDEG_W-1:0]   tdeg_mag;
    logic [SPEED_W-1:0]  speed_mag;
    logic                accept, load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign praw = {frame_byte0[5:0], frame_byte1};
    assign traw = {frame_byte2, frame_byte3[7:5]};
    assign psum = WGT_M1 * SUM_W'(pavg_reg) + SUM_W'(praw);
    assign tsum = WGT_M1 * SUM_W'(tavg_reg) + SUM_W'(traw);

    // one restoring step of the divide by AVG_WEIGHT, both averages
    assign pf_trial = {pf_rem_reg, pf_sh_reg[PRESS_W-1]};
    assign pf_ge    = (pf_trial >= WGT);
    assign pf_diff  = pf_trial - WGT;
    assign tf_trial = {tf_rem_reg, tf_sh_reg[PRESS_W-1]};
    assign tf_ge    = (tf_trial >= WGT);
    assign tf_diff  = tf_trial - WGT;

    // constant multiplies feeding the serial units
    assign sp_prod = 32'(pavg_reg) * 32'(SPEED_GAIN);
    assign sp_d    = {1'b0, sp_prod} - {1'b0, SPEED_OFFSET};
    assign sp_abs  = sp_d[32] ? (33'd0 - sp_d) : sp_d;
    assign tp_num  = 21'(tavg_reg) * 21'(TEMP_GAIN);
    assign tp_neg  = (tp_num < TEMP_OFFSET);
    assign tp_mag  = tp_neg ? (TEMP_OFFSET - tp_num) : (tp_num - TEMP_OFFSET);

    // airspeed radicand divide step
    assign sd_trial = {sd_rem_reg, sd_sh_reg[30]};
    assign sd_ge    = (sd_trial >= {1'b0, SPEED_DIV});
    assign sd_diff  = sd_trial - {1'b0, SPEED_DIV};

    // temperature divide step
    assign td_trial = {td_rem_reg, td_sh_reg[7]};
    assign td_ge    = (td_trial >= {1'b0, TEMP_DIV});
    assign td_diff  = td_trial - {1'b0, TEMP_DIV};

    // square root step: bring in two radicand bits, try root*4 + 1
    assign rt_cur   = {rt_rem_reg, rt_rad_reg[31:30]};
    assign rt_trial = {1'b0, rt_root_reg, 2'b01};
    assign rt_ge    = (rt_cur >= rt_trial);
    assign rt_diff  = rt_cur - rt_trial;

    assign tdeg_mag  = TDEG_W'(td_sh_reg);
    assign speed_mag = rt_root_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        pavg_next      = pavg_reg;
        tavg_next      = tavg_reg;
        status_next    = status_reg;
        pf_rem_next    = pf_rem_reg;
        pf_sh_next     = pf_sh_reg;
        tf_rem_next    = tf_rem_reg;
        tf_sh_next     = tf_sh_reg;
        sd_rem_next    = sd_rem_reg;
        sd_sh_next     = sd_sh_reg;
        td_rem_next    = td_rem_reg;
        td_sh_next     = td_sh_reg;
        td_neg_next    = td_neg_reg;
        rt_rem_next    = rt_rem_reg;
        rt_root_next   = rt_root_reg;
        rt_rad_next    = rt_rad_reg;
        o_status_next  = o_status_reg;
        o_pavg_next    = o_pavg_reg;
        o_tavg_next    = o_tavg_reg;
        o_tdeg_next    = o_tdeg_reg;
        o_speed_next   = o_speed_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = frame_byte0[7:6];
                    cnt_next    = '0;
                    pf_rem_next = psum[SUM_W-1:PRESS_W];
                    pf_sh_next  = psum[PRESS_W-1:0];
                    tf_rem_next = tsum[SUM_W-1:PRESS_W];
                    tf_sh_next  = tsum[PRESS_W-1:0];
                    // skip the average update unless the sample is ready
                    if (frame_byte0[7:6] == STATUS_READY)
                    begin
                        state_next = ST_FOLD;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FOLD:
            begin
                pf_rem_next = pf_ge ? pf_diff[WB-1:0] : pf_trial[WB-1:0];
                pf_sh_next  = {pf_sh_reg[PRESS_W-2:0], pf_ge};
                tf_rem_next = tf_ge ? tf_diff[WB-1:0] : tf_trial[WB-1:0];
                tf_sh_next  = {tf_sh_reg[PRESS_W-2:0], tf_ge};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PRESS_W - 1))
                begin
                    pavg_next  = {pf_sh_reg[PRESS_W-2:0], pf_ge};
                    tavg_next  = tf_sh_next[TEMP_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                sd_rem_next = {1'b0, sp_abs[30:15]};
                sd_sh_next  = {sp_abs[14:0], 16'd0};
                td_rem_next = {1'b0, tp_mag[20:8]};
                td_sh_next  = tp_mag[7:0];
                td_neg_next = tp_neg;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                sd_rem_next = sd_ge ? sd_diff[16:0] : sd_trial[16:0];
                sd_sh_next  = {sd_sh_reg[29:0], sd_ge};
                if (cnt_reg < CNT_W'(TMP_STEPS))
                begin
                    td_rem_next = td_ge ? td_diff[13:0] : td_trial[13:0];
                    td_sh_next  = {td_sh_reg[6:0], td_ge};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SPD_STEPS - 1))
                begin
                    rt_rad_next  = {1'b0, sd_sh_reg[29:0], sd_ge};
                    rt_rem_next  = '0;
                    rt_root_next = '0;
                    cnt_next     = '0;
                    state_next   = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rt_rem_next  = rt_ge ? rt_diff[16:0] : rt_cur[16:0];
                rt_root_next = {rt_root_reg[14:0], rt_ge};
                rt_rad_next  = {rt_rad_reg[29:0], 2'b00};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (load_out)
                begin
                    o_status_next  = status_reg;
                    o_pavg_next    = pavg_reg;
                    o_tavg_next    = tavg_reg;
                    o_tdeg_next    = td_neg_reg ? (TDEG_W'(0) - tdeg_mag) : tdeg_mag;
                    o_speed_next   = (pavg_reg < PRESS_ZERO) ? (SPEED_W'(0) - speed_mag)
                                                             : speed_mag;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pavg_reg      <= '0;
            tavg_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pavg_reg      <= pavg_next;
            tavg_reg      <= tavg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        pf_rem_reg   <= pf_rem_next;
        pf_sh_reg    <= pf_sh_next;
        tf_rem_reg   <= tf_rem_next;
        tf_sh_reg    <= tf_sh_next;
        sd_rem_reg   <= sd_rem_next;
        sd_sh_reg    <= sd_sh_next;
        td_rem_reg   <= td_rem_next;
        td_sh_reg    <= td_sh_next;
        td_neg_reg   <= td_neg_next;
        rt_rem_reg   <= rt_rem_next;
        rt_root_reg  <= rt_root_next;
        rt_rad_reg   <= rt_rad_next;
        o_status_reg <= o_status_next;
        o_pavg_reg   <= o_pavg_next;
        o_tavg_reg   <= o_tavg_next;
        o_tdeg_reg   <= o_tdeg_next;
        o_speed_reg  <= o_speed_next;
    end

    assign out_valid               = out_valid_reg;
    assign sensor_status           = o_status_reg;
    assign pressure_average        = o_pavg_reg;
    assign temp_average            = o_tavg_reg;
    assign temperature_decidegrees = o_tdeg_reg;
    assign airspeed_q8             = o_speed_reg;

endmodule

### src/pfa_check.sv
// ----------------------------------------------------------------------------
// pfa_check: port-level checks for the pitot frame airspeed block
// Watches both channels and the consistency of each result beat.
// ----------------------------------------------------------------------------
module pfa_check
    import pfa_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [BYTE_W-1:0]          frame_byte0,
    input logic [BYTE_W-1:0]          frame_byte1,
    input logic [BYTE_W-1:0]          frame_byte2,
    input logic [BYTE_W-1:0]          frame_byte3,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [STATUS_W-1:0]        sensor_status,
    input logic [PRESS_W-1:0]         pressure_average,
    input logic [TEMP_W-1:0]          temp_average,
    input logic signed [TDEG_W-1:0]   temperature_decidegrees,
    input logic signed [SPEED_W-1:0]  airspeed_q8
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sensor_status)
            && $stable(pressure_average) && $stable(temp_average)
            && $stable(temperature_decidegrees) && $stable(airspeed_q8))
        else $error("result beat changed while stalled");

    // one frame at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a frame is in work");

    // negative airspeed only below zero differential pressure
    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && airspeed_q8[SPEED_W-1] |-> !pressure_average[PRESS_W-1])
        else $error("airspeed sign disagrees with pressure average");

    // below zero degrees only for small temperature counts
    a_temp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && temperature_decidegrees[TDEG_W-1] |-> temp_average < 11'd512)
        else $error("temperature sign disagrees with temperature average");

endmodule

bind pitot_frame_airspeed pfa_check u_pfa_check (.*);

### verif/tb_pitot_frame_airspeed.sv
// ----------------------------------------------------------------------------
// tb_pitot_frame_airspeed: self-checking testbench for the pitot frame decoder
// Sends four-byte sensor frames through a bursty valid/ready driver, predicts
// the running averages, temperature and Q8.8 airspeed of each frame in the
// testbench, and checks every result beat field by field under random
// back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb_pitot_frame_airspeed;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int FRAME_TARGET = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int GAP_MAX      = 100;
    localparam int STALL_MAX    = 400;
    localparam int AVG_N        = AVG_WEIGHT_DEF;

    localparam logic [STATUS_W-1:0] STAT_CMD   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FAULT = 2'd3;

    localparam int       PRESS_MAX = 16383;
    localparam int       TEMP_MAX  = 2047;
    localparam int       PRESS_MID = 8192;
    localparam longint   K_GAIN    = 137411;
    localparam longint   K_OFFSET  = 1125670000;
    localparam longint   K_SCALE   = 65536;
    localparam longint   K_DIV     = 100000;
    localparam longint   T_GAIN    = 1000;
    localparam longint   T_OFFSET  = 511750;
    localparam longint   T_DIV     = 10235;

    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
    } frame_t;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic [PRESS_W-1:0]        press;
        logic [TEMP_W-1:0]         temp;
        logic signed [TDEG_W-1:0]  deci;
        logic signed [SPEED_W-1:0] speed;
    } reading_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_STALL
    } ready_mode_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [BYTE_W-1:0]          frame_byte0 = '0;
    logic [BYTE_W-1:0]          frame_byte1 = '0;
    logic [BYTE_W-1:0]          frame_byte2 = '0;
    logic [BYTE_W-1:0]          frame_byte3 = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATUS_W-1:0]        sensor_status;
    logic [PRESS_W-1:0]         pressure_average;
    logic [TEMP_W-1:0]          temp_average;
    logic signed [TDEG_W-1:0]   temperature_decidegrees;
    logic signed [SPEED_W-1:0]  airspeed_q8;

    frame_t   frame_q[$];
    reading_t reading_q[$];

    logic [PRESS_W-1:0] press_avg = '0;
    logic [TEMP_W-1:0]  temp_avg = '0;

    logic        frame_beat = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_span = 0;
    logic [7:0]  ready_pat = 8'h5A;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          errors = 0;

    pitot_frame_airspeed u_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .frame_byte0             (frame_byte0),
        .frame_byte1             (frame_byte1),
        .frame_byte2             (frame_byte2),
        .frame_byte3             (frame_byte3),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .sensor_status           (sensor_status),
        .pressure_average        (pressure_average),
        .temp_average            (temp_average),
        .temperature_decidegrees (temperature_decidegrees),
        .airspeed_q8             (airspeed_q8)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic frame_t make_frame(logic [STATUS_W-1:0] st, logic [PRESS_W-1:0] p,
                                          logic [TEMP_W-1:0] t, logic [4:0] junk);
        frame_t f;
        f.b0 = {st, p[13:8]};
        f.b1 = p[7:0];
        f.b2 = t[10:3];
        f.b3 = {t[2:0], junk};
        return f;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] airspeed_of(logic [PRESS_W-1:0] p);
        longint                    d;
        longint unsigned           mag;
        longint unsigned           r;
        logic signed [SPEED_W-1:0] s;
        d   = longint'(p) * K_GAIN - K_OFFSET;
        mag = (d < 0) ? -d : d;
        r   = floor_root(mag * K_SCALE / K_DIV);
        s   = r[SPEED_W-1:0];
        return (p < PRESS_ZERO) ? -s : s;
    endfunction

    function automatic logic signed [TDEG_W-1:0] decidegrees_of(logic [TEMP_W-1:0] t);
        longint n;
        // signed divide truncates toward zero, as the readout requires
        n = (longint'(t) * T_GAIN - T_OFFSET) / T_DIV;
        return n[TDEG_W-1:0];
    endfunction

    // Fold a frame into the averages if it is ready, then form the reading it reports.
    function automatic reading_t fold_frame(frame_t f);
        reading_t rd;
        int       praw;
        int       traw;
        rd.status = f.b0[7:6];
        if (rd.status == STATUS_READY)
        begin
            praw      = int'({f.b0[5:0], f.b1});
            traw      = int'({f.b2, f.b3[7:5]});
            press_avg = PRESS_W'(((AVG_N - 1) * int'(press_avg) + praw) / AVG_N);
            temp_avg  = TEMP_W'(((AVG_N - 1) * int'(temp_avg) + traw) / AVG_N);
        end
        rd.press = press_avg;
        rd.temp  = temp_avg;
        rd.deci  = decidegrees_of(temp_avg);
        rd.speed = airspeed_of(press_avg);
        return rd;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Sender: bursts of frames separated by random gaps; junk on idle payload.
    always @(negedge clk)
    begin
        frame_t f;
        if (rst_n && (!in_valid || frame_beat))
        begin
            if (gap_left > 0 || frame_q.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid    <= 1'b0;
                frame_byte0 <= BYTE_W'($urandom);
                frame_byte1 <= BYTE_W'($urandom);
                frame_byte2 <= BYTE_W'($urandom);
                frame_byte3 <= BYTE_W'($urandom);
            end
            else
            begin
                f = frame_q.pop_front();
                in_valid    <= 1'b1;
                frame_byte0 <= f.b0;
                frame_byte1 <= f.b1;
                frame_byte2 <= f.b2;
                frame_byte3 <= f.b3;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
                end
            end
        end
    end

    // Receiver: switch between back-pressure styles at random intervals.
    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(100, 1500);
            ready_pat  = 8'($urandom_range(1, 255));
        end
        else
            ready_span--;
        case (ready_mode)
            RDY_ALWAYS:
                out_ready <= 1'b1;
            RDY_COIN:
                out_ready <= 1'($urandom_range(0, 1));
            RDY_PATTERN:
            begin
                ready_pat = {ready_pat[6:0], ready_pat[7]};
                out_ready <= ready_pat[0];
            end
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        stall_left = $urandom_range(20, STALL_MAX);
                end
            end
        endcase
    end

    // Monitor: predict on each frame beat, check each result beat.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            frame_beat <= in_valid && in_ready;
            if (in_valid && in_ready)
                reading_q.push_back(fold_frame({frame_byte0, frame_byte1,
                                                frame_byte2, frame_byte3}));
            if (out_valid && out_ready)
            begin
                if (reading_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no frame pending, status %0d speed %0d",
                             $time, sensor_status, airspeed_q8);
                end
                else
                begin
                    want = reading_q.pop_front();
                    check_field("sensor_status", want.status, sensor_status);
                    check_field("pressure_average", want.press, pressure_average);
                    check_field("temp_average", want.temp, temp_average);
                    check_field("temperature_decidegrees", want.deci,
                                temperature_decidegrees);
                    check_field("airspeed_q8", want.speed, airspeed_q8);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("pitot_frame_airspeed verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int tgt_p;
        int tgt_t;
        int p;
        int t;
        int run;
        logic [STATUS_W-1:0] st;

        // Directed: empty frame, non-ready statuses with all data bits set,
        // full-scale ready frames, zero-pressure ready frames, junk low bits.
        frame_q.push_back(make_frame(STATUS_READY, 14'd0, 11'd0, 5'd0));
        frame_q.push_back(make_frame(STAT_CMD, 14'h3FFF, 11'h7FF, 5'h1F));
        frame_q.push_back(make_frame(STAT_STALE, 14'h3FFF, 11'h7FF, 5'h1F));
        frame_q.push_back(make_frame(STAT_FAULT, 14'h3FFF, 11'h7FF, 5'h1F));
        repeat (8)
            frame_q.push_back(make_frame(STATUS_READY, 14'h3FFF, 11'h7FF, 5'h1F));
        frame_q.push_back(make_frame(STAT_STALE, 14'd0, 11'd0, 5'd0));
        repeat (5)
            frame_q.push_back(make_frame(STATUS_READY, 14'd8192, 11'd512, 5'h0A));
        frame_q.push_back(make_frame(STATUS_READY, 14'd1, 11'd1, 5'h15));
        frame_q.push_back(make_frame(STATUS_READY, 14'h2AAA, 11'h555, 5'h0A));
        frame_q.push_back(frame_t'(32'hFFFF_FFFF));
        frame_q.push_back(frame_t'(32'h3FFF_FFFF));

        // Random: runs of steady readings with jitter and dropouts, plus noise.
        while (frame_q.size() < FRAME_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 5))
                    0:       tgt_p = PRESS_MID;
                    1:       tgt_p = $urandom_range(0, 1) ? PRESS_MAX : 0;
                    default: tgt_p = $urandom_range(0, PRESS_MAX);
                endcase
                if ($urandom_range(0, 5) == 0)
                    tgt_t = $urandom_range(0, 1) ? TEMP_MAX : 0;
                else
                    tgt_t = $urandom_range(0, TEMP_MAX);
                run = $urandom_range(1, 48);
                repeat (run)
                begin
                    st = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : STATUS_READY;
                    p  = tgt_p;
                    t  = tgt_t;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        p = p + int'($urandom_range(0, 8)) - 4;
                        t = t + int'($urandom_range(0, 8)) - 4;
                    end
                    p = (p < 0) ? 0 : (p > PRESS_MAX) ? PRESS_MAX : p;
                    t = (t < 0) ? 0 : (t > TEMP_MAX) ? TEMP_MAX : t;
                    frame_q.push_back(make_frame(st, p[PRESS_W-1:0], t[TEMP_W-1:0],
                                                 5'($urandom_range(0, 31))));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    frame_q.push_back(frame_t'($urandom));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (frame_q.size() != 0 || in_valid || reading_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("pitot_frame_airspeed verification clean");
        else
            $display("pitot_frame_airspeed verification failed");
        $finish;
    end

endmodule
